// ===== hw/rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and constants of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int MaxBucketsDef = 64;
  localparam int PoolNodesDef  = 256;
  localparam int KeyW          = 32;
  localparam int ValW          = 64;
  localparam int CfgW          = 7;
  localparam int DivCntW       = $clog2(KeyW);
  localparam int BucketCntRst  = 64;

  typedef enum logic [1:0] {
    FN_GET  = 2'd0,
    FN_INS  = 2'd1,
    FN_DEL  = 2'd2,
    FN_RSVD = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_HEAD_RD,
    S_HEAD_LD,
    S_FREE_RD,
    S_INS,
    S_WALK,
    S_NODE_CHK,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] value_out;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    head_rd;
    logic    head_ld;
    logic    free_rd;
    logic    ins_commit;
    logic    node_rd;
    logic    node_adv;
    logic    unlink;
    logic    free_push;
    logic    respond;
    logic    rsp_val;
    status_e rsp_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic is_insert;
    logic is_lookup;
    logic is_remove;
    logic pool_empty;
    logic free_fresh;
    logic cur_none;
    logic key_match;
  } sts_t;

  // A written bucket count of zero acts as one; above the maximum it saturates.
  function automatic logic [CfgW-1:0] clamp_count(logic [CfgW-1:0] v, int max_b);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (int'(v) > max_b) begin
      r = CfgW'(max_b);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/chained_hash_map_top.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Hash map from 32-bit keys to 64-bit values with chained buckets.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and busy stays
// high until it is finished. Each operation first reduces the key modulo the
// bucket count, one bit per cycle, then fetches the bucket head. Insert then
// finishes, reading the free list first when it reuses a freed node; a full
// pool or an unused operation code answers at once. Get and remove walk the
// chain one node at a time, and a remove that hits then frees its node. The
// result appears on rsp_o for exactly one cycle with rsp_valid_o high, in the
// cycle after the last one of the operation, and cannot be held off; it must
// be captured then. Configuration writes are taken only while idle with start
// low and clear the whole table at once.
module chained_hash_map_top #(
  parameter int MaxBuckets = chm_pkg::MaxBucketsDef,
  parameter int PoolNodes  = chm_pkg::PoolNodesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  chm_pkg::req_t            req_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [chm_pkg::CfgW-1:0] cfg_data_i,
  output logic                     rsp_valid_o,
  output chm_pkg::rsp_t            rsp_o
);
  import chm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy_int;

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int && !start;

  chm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy_int),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  chm_dpath #(.MaxBuckets(MaxBuckets), .PoolNodes(PoolNodes)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== hw/rtl/chm_ram.sv =====
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/chm_ctrl.sv =====
// ----------------------------------------------------------------------------
// chm_ctrl
// Controller state machine: sequences modulo, head fetch, insert and walk.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  chm_pkg::sts_t sts_i,
  output chm_pkg::cmd_t cmd_o
);
  import chm_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start) state_d = S_DIV;
      S_DIV:      if (sts_i.div_last) state_d = S_HEAD_RD;
      S_HEAD_RD:  state_d = S_HEAD_LD;
      S_HEAD_LD: begin
        if (sts_i.is_insert) begin
          if (sts_i.pool_empty) state_d = S_IDLE;
          else if (sts_i.free_fresh) state_d = S_INS;
          else state_d = S_FREE_RD;
        end else if (sts_i.is_lookup || sts_i.is_remove) begin
          state_d = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FREE_RD:  state_d = S_INS;
      S_INS:      state_d = S_IDLE;
      S_WALK:     state_d = sts_i.cur_none ? S_IDLE : S_NODE_CHK;
      S_NODE_CHK: begin
        if (!sts_i.key_match) state_d = S_WALK;
        else if (sts_i.is_remove) state_d = S_PUSH;
        else state_d = S_IDLE;
      end
      S_PUSH:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.rsp_status = ST_MISS;
    case (state_q)
      S_IDLE:    cmd_o.load = start;
      S_DIV:     cmd_o.div_step = 1'b1;
      S_HEAD_RD: cmd_o.head_rd = 1'b1;
      S_HEAD_LD: begin
        cmd_o.head_ld = 1'b1;
        if (sts_i.is_insert) begin
          if (sts_i.pool_empty) begin
            cmd_o.respond    = 1'b1;
            cmd_o.rsp_status = ST_FULL;
          end
        end else if (!(sts_i.is_lookup || sts_i.is_remove)) begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_status = ST_MISS;
        end
      end
      S_FREE_RD: cmd_o.free_rd = 1'b1;
      S_INS: begin
        cmd_o.ins_commit = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.rsp_status = ST_OK;
      end
      S_WALK: begin
        if (sts_i.cur_none) begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_status = ST_MISS;
        end else begin
          cmd_o.node_rd = 1'b1;
        end
      end
      S_NODE_CHK: begin
        if (!sts_i.key_match) begin
          cmd_o.node_adv = 1'b1;
        end else if (sts_i.is_remove) begin
          cmd_o.unlink = 1'b1;
        end else begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_val    = 1'b1;
          cmd_o.rsp_status = ST_OK;
        end
      end
      S_PUSH: begin
        cmd_o.free_push  = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.rsp_val    = 1'b1;
        cmd_o.rsp_status = ST_OK;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // Every transaction ends with the machine back in idle.
  a_resp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |=> !busy) else $error("controller not idle after response");

  // A remove that matched always frees its node in the next cycle.
  a_unlink_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.unlink |=> cmd_o.free_push) else $error("unlinked node not freed");

endmodule

// ===== hw/rtl/chm_dpath.sv =====
// ----------------------------------------------------------------------------
// chm_dpath
// Datapath: bit-serial modulo, bucket head RAM, node RAMs and free list.
// ----------------------------------------------------------------------------
module chm_dpath #(
  parameter int MaxBuckets = chm_pkg::MaxBucketsDef,
  parameter int PoolNodes  = chm_pkg::PoolNodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chm_pkg::req_t              req_i,
  input  logic                       cfg_we_i,
  input  logic [chm_pkg::CfgW-1:0]   cfg_data_i,
  input  chm_pkg::cmd_t              cmd_i,
  output chm_pkg::sts_t              sts_o,
  output logic                       rsp_valid_o,
  output chm_pkg::rsp_t              rsp_o
);
  import chm_pkg::*;

  localparam int BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int NW = $clog2(PoolNodes + 1);
  localparam int AW = $clog2(PoolNodes);
  localparam logic [NW-1:0] NoNode = NW'(PoolNodes);
  localparam logic [CfgW-1:0] BcntRst =
    CfgW'((MaxBuckets < BucketCntRst) ? MaxBuckets : BucketCntRst);

  // Request and walk registers.
  logic [1:0]         func_q;
  logic [KeyW-1:0]    key_q, dkey_q;
  logic [ValW-1:0]    val_q;
  logic [CfgW-1:0]    rem_q, bcnt_q;
  logic [DivCntW-1:0] cnt_q;
  logic               head_vld_q;
  logic [NW-1:0]      cur_q, prev_q, free_head_q, fc_q;
  logic [MaxBuckets-1:0] hvalid_q;
  logic               rsp_valid_q;
  rsp_t               rsp_q;

  logic [BW-1:0]      bucket;
  logic [CfgW:0]      trial;
  logic [CfgW-1:0]    rem_d;

  // RAM ports.
  logic               hd_we;
  logic [NW-1:0]      hd_wdata, hd_rdata;
  logic               nx_we, nx_re;
  logic [AW-1:0]      nx_waddr, nx_raddr;
  logic [NW-1:0]      nx_wdata, nx_rdata;
  logic [KeyW+ValW-1:0] kv_rdata;

  assign bucket = BW'(rem_q);

  // One restoring step of key modulo bucket count.
  always_comb begin
    trial = {rem_q, dkey_q[KeyW-1]};
    if (trial >= {1'b0, bcnt_q}) begin
      rem_d = CfgW'(trial - {1'b0, bcnt_q});
    end else begin
      rem_d = trial[CfgW-1:0];
    end
  end

  // Request capture and modulo iteration.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= req_i.func;
      key_q  <= req_i.key;
      dkey_q <= req_i.key;
      val_q  <= req_i.value_in;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      dkey_q <= {dkey_q[KeyW-2:0], 1'b0};
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // Chain walk pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) begin
      head_vld_q <= hvalid_q[bucket];
    end
    if (cmd_i.head_ld) begin
      cur_q  <= head_vld_q ? hd_rdata : NoNode;
      prev_q <= NoNode;
    end else if (cmd_i.node_adv) begin
      prev_q <= cur_q;
      cur_q  <= nx_rdata;
    end
  end

  // Bucket count, valid bits and free list; a config write clears the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q      <= BcntRst;
      hvalid_q    <= '0;
      free_head_q <= '0;
      fc_q        <= '0;
    end else if (cfg_we_i) begin
      bcnt_q      <= clamp_count(cfg_data_i, MaxBuckets);
      hvalid_q    <= '0;
      free_head_q <= '0;
      fc_q        <= '0;
    end else if (cmd_i.ins_commit) begin
      hvalid_q[bucket] <= 1'b1;
      if (free_head_q == fc_q) begin
        free_head_q <= free_head_q + NW'(1);
        fc_q        <= fc_q + NW'(1);
      end else begin
        free_head_q <= nx_rdata;
      end
    end else if (cmd_i.free_push) begin
      free_head_q <= cur_q;
    end
  end

  // Bucket head RAM writes.
  always_comb begin
    hd_we    = cmd_i.ins_commit || (cmd_i.unlink && (prev_q == NoNode));
    hd_wdata = cmd_i.ins_commit ? free_head_q : nx_rdata;
  end

  // Next-link RAM port selection.
  always_comb begin
    nx_re    = cmd_i.free_rd || cmd_i.node_rd;
    nx_raddr = cmd_i.free_rd ? free_head_q[AW-1:0] : cur_q[AW-1:0];
    nx_we    = cmd_i.ins_commit || cmd_i.free_push ||
               (cmd_i.unlink && (prev_q != NoNode));
    nx_waddr = cur_q[AW-1:0];
    nx_wdata = free_head_q;
    if (cmd_i.ins_commit) begin
      nx_waddr = free_head_q[AW-1:0];
      nx_wdata = cur_q;
    end else if (cmd_i.unlink) begin
      nx_waddr = prev_q[AW-1:0];
      nx_wdata = nx_rdata;
    end
  end

  chm_ram #(.Width(NW), .Depth(MaxBuckets)) u_heads (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (bucket),
    .wdata_i (hd_wdata),
    .re_i    (cmd_i.head_rd),
    .raddr_i (bucket),
    .rdata_o (hd_rdata)
  );

  chm_ram #(.Width(NW), .Depth(PoolNodes)) u_next (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (nx_re),
    .raddr_i (nx_raddr),
    .rdata_o (nx_rdata)
  );

  chm_ram #(.Width(KeyW + ValW), .Depth(PoolNodes)) u_kv (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_commit),
    .waddr_i (free_head_q[AW-1:0]),
    .wdata_i ({key_q, val_q}),
    .re_i    (cmd_i.node_rd),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (kv_rdata)
  );

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.div_last   = (cnt_q == DivCntW'(KeyW - 1));
    sts_o.is_insert  = (func_q == FN_INS);
    sts_o.is_lookup  = (func_q == FN_GET);
    sts_o.is_remove  = (func_q == FN_DEL);
    sts_o.pool_empty = (free_head_q == NoNode);
    sts_o.free_fresh = (free_head_q == fc_q);
    sts_o.cur_none   = (cur_q == NoNode);
    sts_o.key_match  = (kv_rdata[KeyW+ValW-1:ValW] == key_q);
  end

  // Result register; the strobe lasts one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      rsp_q.status    <= cmd_i.rsp_status;
      rsp_q.value_out <= cmd_i.rsp_val ? kv_rdata[ValW-1:0] : '0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Freed nodes always lie below the fresh-node mark.
  a_free_le_fc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= fc_q) else $error("free head beyond fresh mark");

  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= NoNode) else $error("fresh mark beyond pool");

  a_ins_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_commit |-> (free_head_q != NoNode)) else $error("insert from empty pool");

endmodule
